[hdl/slot_table_with_free_stack_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the slot table
// Concurrent checks on clk, disabled during rst; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SLOT_TABLE_WITH_FREE_STACK_UNIT_DEFINES_SVH
`define SLOT_TABLE_WITH_FREE_STACK_UNIT_DEFINES_SVH

`ifndef SYNTH
`define ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_NOW(lbl, cond)
`define ASSERT_NEXT(lbl, pre, post)
`endif

`endif

[hdl/stfs_pkg.sv]
// ----------------------------------------------------------------------------
// stfs_pkg
// Sizes, codes and control types shared by the slot table files.
// ----------------------------------------------------------------------------
package stfs_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int VAL_W  = 32;

  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(SLOTS);

  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [SLOT_W-1:0] slot;
  } stk_ctl_t;

  typedef struct packed {
    logic [SLOT_W-1:0] top;
    logic [CNT_W-1:0]  count;
  } stk_state_t;

endpackage

[hdl/stfs_if.sv]
// ----------------------------------------------------------------------------
// stfs_in_if / stfs_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface stfs_in_if import stfs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              cmd;
  logic signed [VAL_W-1:0] value;
  logic [SLOT_W-1:0]       slot;

  modport source (output valid, cmd, value, slot, input ready);
  modport sink   (input valid, cmd, value, slot, output ready);
endinterface

interface stfs_out_if import stfs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [SLOT_W-1:0] slot_used;

  modport source (output valid, status, slot_used, input ready);
  modport sink   (input valid, status, slot_used, output ready);
endinterface

[hdl/stfs_free_stack.sv]
// ----------------------------------------------------------------------------
// stfs_free_stack
// LIFO of freed slots in a RAM with registered read; the top is held
// in a register after a push, or taken from the read port after a pop.
// ----------------------------------------------------------------------------
`include "slot_table_with_free_stack_unit_defines.svh"

module stfs_free_stack import stfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  stk_ctl_t   ctl,
  output stk_state_t st
);

  logic [SLOT_W-1:0] mem [SLOTS];
  logic [SLOT_W-1:0] rd_data;
  logic [SLOT_W-1:0] top_reg;
  logic              use_rd;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              push_ok;
  logic              pop_ok;
  logic [SLOT_W-1:0] rd_addr;

  assign push_ok = ctl.push && (count < CNT_W'(SLOTS));
  assign pop_ok  = ctl.pop && (count != '0);
  // entry below the current top, which is the new top after a pop
  assign rd_addr = SLOT_W'(count - CNT_W'(2));

  always_comb begin
    count_next = count;
    if (ctl.clear) begin
      count_next = '0;
    end else if (push_ok) begin
      count_next = count + CNT_W'(1);
    end else if (pop_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[count[SLOT_W-1:0]] <= ctl.slot;
    end
    if (pop_ok) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      top_reg <= ctl.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      use_rd <= 1'b0;
    end else begin
      count <= count_next;
      if (push_ok) begin
        use_rd <= 1'b0;
      end else if (pop_ok) begin
        use_rd <= 1'b1;
      end
    end
  end

  assign st.top   = use_rd ? rd_data : top_reg;
  assign st.count = count;

  `ASSERT_NOW(a_count_bound, count <= CNT_W'(SLOTS))
  `ASSERT_NOW(a_no_push_pop, !(ctl.push && ctl.pop))
  `ASSERT_NEXT(a_push_top, push_ok && !ctl.clear, st.top == $past(ctl.slot))
  `ASSERT_NEXT(a_clear_empty, ctl.clear, count == '0)

endmodule

[hdl/slot_table_with_free_stack_unit.sv]
// ----------------------------------------------------------------------------
// slot_table_with_free_stack_unit
// Slot allocator: put stores a value in a reused or fresh slot, remove
// frees a slot onto a LIFO, clear restarts the allocation.
// ----------------------------------------------------------------------------
// Usage:
//   req carries command words (cmd, value, slot); rsp returns one result
//   word (status, slot_used) for every command word, in order.
//   cfg_we/cfg_wdata write capacity; write it only while the unit is idle.
//   A command word is decoded in the cycle it is taken and its result is
//   registered, so rsp.valid rises in the cycle after acceptance.
//   Throughput is one word per cycle while rsp is taken; the freed-slot RAM is read on a pop
//   into a registered top, so back-to-back puts and removes need no wait.
//   req.ready is high whenever the result register is empty or being
//   taken, so a stalled receiver holds the result and blocks new words.
//   After rst: capacity 64, no slots handed out, free stack empty, bitmap
//   clear. No clearing pass; the value store and stack RAM are not reset.
// ----------------------------------------------------------------------------
`include "slot_table_with_free_stack_unit_defines.svh"

module slot_table_with_free_stack_unit import stfs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  stfs_in_if.sink          req,
  stfs_out_if.source       rsp
);

  logic [CNT_W-1:0]        capacity;
  logic [CNT_W-1:0]        high_water;
  logic [CNT_W-1:0]        high_water_next;
  logic [SLOTS-1:0]        occupied;
  logic signed [VAL_W-1:0] values [SLOTS];
  logic                    rsp_valid;
  logic [1:0]              rsp_status;
  logic [SLOT_W-1:0]       rsp_slot_used;

  logic              accept;
  logic [CNT_W-1:0]  eff_cap;
  logic              reuse;
  logic              fresh;
  logic              put_ok;
  logic              rm_range;
  logic              rm_empty;
  logic              rm_ok;
  logic [SLOT_W-1:0] put_slot;
  logic [1:0]        status_next;
  logic [SLOT_W-1:0] slot_used_next;
  stk_ctl_t          stk_ctl;
  stk_state_t        stk_st;

  stfs_free_stack u_stack (
    .clk (clk),
    .rst (rst),
    .ctl (stk_ctl),
    .st  (stk_st)
  );

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;

  assign eff_cap  = (capacity > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : capacity;
  assign reuse    = stk_st.count != '0;
  assign fresh    = !reuse && (high_water < eff_cap);
  assign put_slot = reuse ? stk_st.top : high_water[SLOT_W-1:0];
  assign put_ok   = (req.cmd == CMD_PUT) && (reuse || fresh);
  assign rm_range = {1'b0, req.slot} >= high_water;
  assign rm_empty = !occupied[req.slot];
  assign rm_ok    = (req.cmd == CMD_REMOVE) && !rm_range && !rm_empty;

  assign stk_ctl.push  = accept && rm_ok;
  assign stk_ctl.pop   = accept && (req.cmd == CMD_PUT) && reuse;
  assign stk_ctl.clear = accept && (req.cmd == CMD_CLEAR);
  assign stk_ctl.slot  = req.slot;

  always_comb begin
    status_next     = ST_OK;
    slot_used_next  = '0;
    high_water_next = high_water;
    case (req.cmd)
      CMD_PUT: begin
        if (put_ok) begin
          slot_used_next = put_slot;
          if (!reuse) begin
            high_water_next = high_water + CNT_W'(1);
          end
        end else begin
          status_next = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (rm_range) begin
          status_next = ST_RANGE;
        end else if (rm_empty) begin
          status_next = ST_EMPTY;
        end else begin
          slot_used_next = req.slot;
        end
      end
      CMD_CLEAR: begin
        high_water_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && put_ok) begin
      values[put_slot] <= req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status    <= status_next;
      rsp_slot_used <= slot_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      high_water <= '0;
      occupied   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        high_water <= high_water_next;
        if (put_ok) begin
          occupied[put_slot] <= 1'b1;
        end else if (rm_ok) begin
          occupied[req.slot] <= 1'b0;
        end
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.slot_used = rsp_slot_used;

  `ASSERT_NOW(a_hw_bound, high_water <= CNT_W'(SLOTS))
  `ASSERT_NEXT(a_put_marks, accept && put_ok, occupied[$past(put_slot)])
  `ASSERT_NEXT(a_fresh_step, accept && put_ok && fresh, high_water == $past(high_water) + CNT_W'(1))
  `ASSERT_NEXT(a_rm_frees, accept && rm_ok, !occupied[$past(req.slot)])
  `ASSERT_NOW(a_stack_le_hw, stk_st.count <= high_water)

endmodule

[test/slot_table_with_free_stack_unit_test.sv]
// ----------------------------------------------------------------------------
// slot_table_with_free_stack_unit_test
// Self-checking bench for the slot allocator. Command words are driven over
// the request channel in bursts, and the result channel stalls on its own
// pattern. A behavioural copy of the table, with its high-water mark,
// freed-slot LIFO and bitmap, predicts each result word, which is checked
// in order. Directed cases come first, then random phases at several
// capacities.
// ----------------------------------------------------------------------------
module slot_table_with_free_stack_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import stfs_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_used;
  } outcome_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  stfs_in_if  req_if ();
  stfs_out_if rsp_if ();

  slot_table_with_free_stack_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // behavioural copy of the table
  logic [CNT_W-1:0]  cap_now;
  logic [CNT_W-1:0]  mark;
  logic [CNT_W-1:0]  freed_n;
  logic [SLOT_W-1:0] freed [SLOTS];
  logic [SLOTS-1:0]  in_use;

  outcome_t outcomes_due[$];
  outcome_t head;
  int       errors = 0;
  int       words_seen = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic outcome_t table_step(logic [1:0] cmd, logic [SLOT_W-1:0] slot);
    outcome_t         r;
    logic [CNT_W-1:0] lim;
    r = '{status: ST_OK, slot_used: '0};
    lim = (cap_now > SLOTS) ? CNT_W'(SLOTS) : cap_now;
    case (cmd)
      CMD_PUT: begin
        if (freed_n != 0) begin
          freed_n = freed_n - 1'b1;
          r.slot_used = freed[freed_n[SLOT_W-1:0]];
        end else if (mark < lim) begin
          r.slot_used = mark[SLOT_W-1:0];
          mark = mark + 1'b1;
        end else begin
          r.status = ST_FULL;
        end
        if (r.status == ST_OK) in_use[r.slot_used] = 1'b1;
      end
      CMD_REMOVE: begin
        if (CNT_W'(slot) >= mark) begin
          r.status = ST_RANGE;
        end else if (!in_use[slot]) begin
          r.status = ST_EMPTY;
        end else begin
          in_use[slot] = 1'b0;
          if (freed_n < SLOTS) begin
            freed[freed_n[SLOT_W-1:0]] = slot;
            freed_n = freed_n + 1'b1;
          end
          r.slot_used = slot;
        end
      end
      CMD_CLEAR: begin
        mark = '0;
        freed_n = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag(string what);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      words_seen++;
      if (outcomes_due.size() == 0) begin
        flag($sformatf("result word %0d with no command outstanding", words_seen));
      end else begin
        head = outcomes_due.pop_front();
        if (rsp_if.status !== head.status || rsp_if.slot_used !== head.slot_used)
          flag($sformatf("word %0d: status exp %0d got %0d, slot_used exp %0d got %0d",
                         words_seen, head.status, rsp_if.status,
                         head.slot_used, rsp_if.slot_used));
      end
    end
  end

  initial begin : result_stall
    int mode;
    int span;
    int k;
    rsp_if.ready = 1'b0;
    forever begin
      mode = $urandom_range(3);
      span = $urandom_range(200, 20);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0:       rsp_if.ready <= 1'b1;
          1:       rsp_if.ready <= ($urandom_range(9) < 7);
          2:       rsp_if.ready <= (k % 7) > 2;
          default: rsp_if.ready <= (k % 24) >= 12;
        endcase
      end
    end
  end

  task automatic send_word(logic [1:0] c, logic [VAL_W-1:0] v, logic [SLOT_W-1:0] s);
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.cmd   <= c;
    req_if.value <= v;
    req_if.slot  <= s;
    do @(posedge clk); while (!req_if.ready);
    outcomes_due.push_back(table_step(c, s));
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    req_if.valid <= 1'b0;
    repeat (n - 1) @(posedge clk);
  endtask

  task automatic await_idle();
    pause_sender(1);
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CNT_W-1:0] v);
    await_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cap_now = v;
  endtask

  task automatic test_first_puts();
    send_word(CMD_REMOVE, 32'h0, 6'd0);
    send_word(CMD_PUT, 32'h7fffffff, 6'd0);
    send_word(CMD_PUT, 32'h80000000, 6'd63);
    send_word(CMD_PUT, 32'h0, 6'd0);
    send_word(CMD_PUT, 32'hffffffff, 6'd0);
    send_word(CMD_REMOVE, 32'h0, 6'd63);
  endtask

  task automatic test_remove_and_reuse();
    send_word(CMD_REMOVE, 32'h0, 6'd2);
    send_word(CMD_REMOVE, 32'h0, 6'd2);
    send_word(CMD_REMOVE, 32'hffffffff, 6'd0);
    send_word(CMD_PUT, $urandom, 6'd0);
    send_word(CMD_PUT, $urandom, 6'd0);
    send_word(CMD_PUT, $urandom, 6'd0);
  endtask

  // mark stays above a lowered capacity; freed slots are still handed out
  task automatic test_capacity_below_mark();
    set_capacity(7'd2);
    send_word(CMD_PUT, $urandom, 6'd0);
    send_word(CMD_REMOVE, 32'h0, 6'd3);
    send_word(CMD_PUT, $urandom, 6'd0);
    send_word(CMD_PUT, $urandom, 6'd0);
  endtask

  task automatic test_capacity_extremes();
    set_capacity(7'd0);
    send_word(CMD_CLEAR, 32'h0, 6'd0);
    send_word(CMD_PUT, $urandom, 6'd0);
    set_capacity(7'd1);
    send_word(CMD_PUT, $urandom, 6'd0);
    send_word(CMD_PUT, $urandom, 6'd0);
    set_capacity(7'd127);
    send_word(CMD_PUT, $urandom, 6'd0);
    set_capacity(CAP_RESET);
  endtask

  task automatic test_clear_and_spare();
    send_word(CMD_SPARE, $urandom, 6'($urandom));
    send_word(CMD_CLEAR, $urandom, 6'($urandom));
    send_word(CMD_PUT, $urandom, 6'd0);
  endtask

  task automatic test_random_traffic(int total);
    int                sent;
    int                phase;
    int                phase_len;
    int                put_pct;
    int                burst;
    int                hold_at;
    int                pick;
    int                i;
    int                j;
    logic [CNT_W-1:0]  capv;
    logic [1:0]        c;
    logic [VAL_W-1:0]  v;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] live[$];
    sent = 0;
    phase = 0;
    hold_at = $urandom_range(total - 100, 100);
    while (sent < total) begin
      case (phase)
        0:       capv = 7'd64;
        1:       capv = 7'd1;
        2:       capv = 7'd127;
        3:       capv = 7'd0;
        4:       capv = 7'd2;
        default: capv = ($urandom_range(7) == 0) ? 7'($urandom_range(127, 65))
                                                 : 7'($urandom_range(64, 1));
      endcase
      set_capacity(capv);
      put_pct   = $urandom_range(80, 35);
      phase_len = $urandom_range(250, 60);
      burst     = $urandom_range(40, 1);
      for (i = 0; i < phase_len && sent < total; i++) begin
        if (sent == hold_at) await_idle();
        pick = $urandom_range(99);
        if (pick < 3)                c = CMD_CLEAR;
        else if (pick < 4)           c = CMD_SPARE;
        else if (pick < 4 + put_pct) c = CMD_PUT;
        else                         c = CMD_REMOVE;
        v = $urandom;
        if ($urandom_range(15) == 0) begin
          case ($urandom_range(3))
            0:       v = 32'h80000000;
            1:       v = 32'h7fffffff;
            2:       v = 32'h0;
            default: v = 32'hffffffff;
          endcase
        end
        s = $urandom_range(63);
        if (c == CMD_REMOVE && $urandom_range(3) != 0) begin
          live.delete();
          for (j = 0; j < mark; j++)
            if (in_use[j]) live.push_back(SLOT_W'(j));
          if (live.size() != 0) s = live[$urandom_range(live.size() - 1)];
        end
        send_word(c, v, s);
        sent++;
        burst--;
        if (burst == 0) begin
          if ($urandom_range(5) != 0) pause_sender($urandom_range(8, 1));
          burst = $urandom_range(40, 1);
        end
      end
      phase++;
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.cmd   = CMD_PUT;
    req_if.value = '0;
    req_if.slot  = '0;
    cap_now      = CAP_RESET;
    mark         = '0;
    freed_n      = '0;
    in_use       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_puts();
    test_remove_and_reuse();
    test_capacity_below_mark();
    test_capacity_extremes();
    test_clear_and_spare();
    test_random_traffic(1850);

    await_idle();
    repeat (5) @(posedge clk);
    if (errors == 0 && outcomes_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
